/* design/gaussian_pyramid_reduce_5x5_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian pyramid reduce block
// Shared helpers for the concurrent checks; clk_i and rst_ni must be in scope.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_PYRAMID_REDUCE_5X5_ASSERT_SVH
`define GAUSSIAN_PYRAMID_REDUCE_5X5_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define GPR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that, once seen, implies another one on the following edge.
`define GPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* design/gpr5x5_pkg.sv */
// ----------------------------------------------------------------------------
// Gaussian pyramid reduce package
// Field widths, register indexes, line store word and result types.
// ----------------------------------------------------------------------------
package gpr5x5_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DIM_RST = 2048;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDING   = 2'd2;

  // Horizontal and vertical partial sum widths.
  localparam int ROW_PART_W = 11;
  localparam int ROW_ODD_W  = 10;
  localparam int HSUM_W     = 12;
  localparam int CUR_W      = 12;
  localparam int UPPER_W    = 15;
  localparam int ODD_W      = 14;
  localparam int SUM_W      = 16;

  localparam logic [SUM_W-1:0] ROUND_BIAS = 16'd128;

  localparam int OUT_FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W     = 2;
  localparam int FIFO_CNT_W     = 3;

  typedef enum logic [2:0] {
    EV_FIRST,
    EV_ODD,
    EV_EVEN,
    EV_FLUSH_ODDH,
    EV_FLUSH_EVENH
  } ev_kind_e;

  // One entry of the column line store: the three vertical partial sums.
  typedef struct packed {
    logic [ODD_W-1:0]   odd;
    logic [UPPER_W-1:0] upper;
    logic [CUR_W-1:0]   cur;
  } line_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             frame_end;
    logic             last;
  } result_t;

endpackage

/* design/gaussian_pyramid_reduce_5x5.sv */
// ----------------------------------------------------------------------------
// Gaussian pyramid reduce, 5x5 binomial kernel
// Halves an 8-bit gray image with the [1 4 6 4 1] x [1 4 6 4 1] kernel.
// ----------------------------------------------------------------------------
// Usage:
// Source pixels enter on the slave stream in raster order with tuser low.
// After the last pixel of the frame, one transfer with tuser high per output
// column produces the final output row; a pixel sent then is dropped.
// Results leave on the master stream: tdata is the reduced pixel, tuser
// marks row and frame end, tlast marks the last result of an input transfer.
// An item is taken every cycle while s_axis_tready_o is high; a pixel
// closing an even row on an even column gives two results. A result is
// registered with its line store read, then in the result buffer. The
// line store sets the rate: its even and odd column banks each see one
// read and one write per cycle. When the receiver stalls, results queue
// in a four-entry buffer; s_axis_tready_o drops with fewer than two free.
// Reset sets width and height to 2048 (or the maximum if smaller), turns
// rounding on and clears the frame position. The line stores are not
// cleared: the first row of each frame writes every entry read later.
// Writing width or height abandons the frame in progress.
// ----------------------------------------------------------------------------
`include "gaussian_pyramid_reduce_5x5_assert.svh"

module gaussian_pyramid_reduce_5x5 #(
  parameter int MAX_SRC_WIDTH  = 2048,
  parameter int MAX_SRC_HEIGHT = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [gpr5x5_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gpr5x5_pkg::CFG_W-1:0]      cfg_data_i,
  // Source stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,   // [7:0] pixel
  input  logic                              s_axis_tuser_i,   // [0] operation
  // Result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,   // [7:0] out_pixel
  output logic [1:0]                        m_axis_tuser_o,   // [0] row_end, [1] frame_end
  output logic                              m_axis_tlast_o
);
  import gpr5x5_pkg::*;

  localparam int LINE_DEPTH = (MAX_SRC_WIDTH + 1) / 2 + 1;
  localparam int KW    = ($clog2(LINE_DEPTH) > 2) ? $clog2(LINE_DEPTH) : 2;
  localparam int AW    = KW - 1;
  localparam int BANK_DEPTH = (LINE_DEPTH + 1) / 2;
  localparam int WW    = $clog2(MAX_SRC_WIDTH + 1);
  localparam int WW1   = WW + 1;
  localparam int HW    = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int HW1   = HW + 1;
  localparam int XW    = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int YW    = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
  localparam int W_RST = (MAX_SRC_WIDTH < CFG_DIM_RST) ? MAX_SRC_WIDTH : CFG_DIM_RST;
  localparam int H_RST = (MAX_SRC_HEIGHT < CFG_DIM_RST) ? MAX_SRC_HEIGHT : CFG_DIM_RST;
  localparam int CNT_W1 = FIFO_CNT_W + 1;

  typedef struct packed {
    logic             valid;
    ev_kind_e         kind;
    logic [KW-1:0]    k;
    logic [HSUM_W-1:0] s;
    logic             last;
  } slot_t;

  // Configuration
  logic [WW-1:0] w_q, w_new;
  logic [KW-1:0] dst_w_q, dst_new;
  logic [HW-1:0] h_q, h_new;
  logic          round_q;

  // Frame position and horizontal sums
  logic [PIX_W-1:0]      prev_q, prev_d;
  logic [ROW_PART_W-1:0] part_q, part_d;
  logic [ROW_ODD_W-1:0]  odd4_q, odd4_d;
  logic [XW-1:0]         col_q, col_d;
  logic [YW-1:0]         row_q, row_d;
  logic [KW-1:0]         fk_q, fk_d;
  logic                  fpend_q, fpend_d;

  logic                  accept, op_flush, last_col, last_row, px0, x_even;
  logic [PIX_W-1:0]      p;
  logic [XW:0]           x_inc;
  logic [YW:0]           y_inc;
  logic [KW-1:0]         k_a;
  logic [ROW_PART_W-1:0] part_even, part_first;
  logic [HSUM_W-1:0]     s_mid, s_last_even, s_last_odd;
  ev_kind_e              kind_row;

  slot_t slot_d [2];
  slot_t s1_q [2];

  // Line store and column arithmetic
  line_word_t        bank_rdata [2];
  line_word_t        bwdata [2];
  logic              bwe [2];
  logic              bre [2];
  logic [AW-1:0]     bwaddr [2];
  logic [AW-1:0]     braddr [2];
  line_word_t        rd [2];
  line_word_t        wr_word [2];
  logic              wr_en [2];
  logic              has_res [2];
  logic [SUM_W-1:0]  sum [2];
  logic [SUM_W-1:0]  scaled [2];
  result_t           res [2];

  logic [1:0]            push_n;
  result_t               push0, head;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic                  pop;

  // --------------------------------------------------------------------------
  // Configuration registers; geometry is clamped as it is written.
  // --------------------------------------------------------------------------
  always_comb begin
    if (cfg_data_i == '0) begin
      w_new = WW'(1);
      h_new = HW'(1);
    end else begin
      w_new = (32'(cfg_data_i) > MAX_SRC_WIDTH)  ? WW'(MAX_SRC_WIDTH)  : WW'(cfg_data_i);
      h_new = (32'(cfg_data_i) > MAX_SRC_HEIGHT) ? HW'(MAX_SRC_HEIGHT) : HW'(cfg_data_i);
    end
    dst_new = KW'((WW1'(w_new) + WW1'(1)) >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= WW'(W_RST);
      dst_w_q <= KW'((W_RST + 1) / 2);
      h_q     <= HW'(H_RST);
      round_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_WIDTH: begin
          w_q     <= w_new;
          dst_w_q <= dst_new;
        end
        REG_SRC_HEIGHT: h_q <= h_new;
        REG_ROUNDING:   round_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: horizontal 5-tap sums and column events.
  // --------------------------------------------------------------------------
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign op_flush = s_axis_tuser_i;
  assign p        = s_axis_tdata_i;
  assign px0      = (col_q == '0);
  assign x_even   = ~col_q[0];
  assign x_inc    = {1'b0, col_q} + 1'b1;
  assign y_inc    = {1'b0, row_q} + 1'b1;
  assign k_a      = KW'(x_inc[XW:1]);
  assign last_col = WW1'(x_inc) >= WW1'(w_q);
  assign last_row = HW1'(y_inc) >= HW1'(h_q);

  assign part_even  = ROW_PART_W'(prev_q) + ROW_PART_W'(odd4_q);
  assign part_first = ROW_PART_W'({p, 2'b00}) + ROW_PART_W'(p);
  assign s_mid = HSUM_W'(part_q) + HSUM_W'({prev_q, 2'b00}) + HSUM_W'({prev_q, 1'b0})
               + HSUM_W'(odd4_q) + HSUM_W'(p);
  assign s_last_even = HSUM_W'(px0 ? part_first : part_even) + HSUM_W'({p, 3'b000})
                     + HSUM_W'({p, 1'b0}) + HSUM_W'(p);
  assign s_last_odd = HSUM_W'(part_q) + HSUM_W'({prev_q, 2'b00}) + HSUM_W'({prev_q, 1'b0})
                    + HSUM_W'({p, 2'b00}) + HSUM_W'(p);

  always_comb begin
    if (row_q == '0) begin
      kind_row = EV_FIRST;
    end else if (row_q[0]) begin
      kind_row = EV_ODD;
    end else begin
      kind_row = EV_EVEN;
    end
  end

  always_comb begin
    prev_d  = prev_q;
    part_d  = part_q;
    odd4_d  = odd4_q;
    col_d   = col_q;
    row_d   = row_q;
    fk_d    = fk_q;
    fpend_d = fpend_q;
    slot_d[0] = '0;
    slot_d[1] = '0;

    if (accept && op_flush && fpend_q) begin
      slot_d[0].valid = 1'b1;
      slot_d[0].kind  = h_q[0] ? EV_FLUSH_ODDH : EV_FLUSH_EVENH;
      slot_d[0].k     = fk_q;
      slot_d[0].last  = 1'b1;
      if (fk_q >= dst_w_q) begin
        fpend_d = 1'b0;
        fk_d    = KW'(1);
      end else begin
        fk_d = fk_q + 1'b1;
      end
    end else if (accept && !op_flush && !fpend_q) begin
      if (px0) begin
        prev_d = p;
        part_d = part_first;
        odd4_d = ROW_ODD_W'({p, 2'b00});
      end else if (x_even) begin
        slot_d[0].valid = 1'b1;
        slot_d[0].kind  = kind_row;
        slot_d[0].k     = k_a;
        slot_d[0].s     = s_mid;
        slot_d[0].last  = ~last_col;
        part_d = part_even;
        prev_d = p;
      end else begin
        odd4_d = ROW_ODD_W'({p, 2'b00});
      end

      if (last_col) begin
        // The closing event of a row covers the replicated right edge.
        slot_d[1].valid = 1'b1;
        slot_d[1].kind  = kind_row;
        slot_d[1].k     = x_even ? KW'(k_a + 1'b1) : k_a;
        slot_d[1].s     = x_even ? s_last_even : s_last_odd;
        slot_d[1].last  = 1'b1;
        col_d = '0;
        if (last_row) begin
          row_d   = '0;
          fpend_d = 1'b1;
          fk_d    = KW'(1);
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end

    if (cfg_we_i && (cfg_idx_i == REG_SRC_WIDTH || cfg_idx_i == REG_SRC_HEIGHT)) begin
      prev_d  = '0;
      part_d  = '0;
      odd4_d  = '0;
      col_d   = '0;
      row_d   = '0;
      fk_d    = KW'(1);
      fpend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      part_q  <= '0;
      odd4_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      fk_q    <= KW'(1);
      fpend_q <= 1'b0;
      s1_q[0] <= '0;
      s1_q[1] <= '0;
    end else begin
      prev_q  <= prev_d;
      part_q  <= part_d;
      odd4_q  <= odd4_d;
      col_q   <= col_d;
      row_q   <= row_d;
      fk_q    <= fk_d;
      fpend_q <= fpend_d;
      s1_q[0] <= slot_d[0];
      s1_q[1] <= slot_d[1];
    end
  end

  // --------------------------------------------------------------------------
  // Line store: even and odd columns in separate banks. Two events of one
  // transfer always fall on neighbouring columns, so each bank sees at most
  // one of them.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      bre[b]    = 1'b0;
      braddr[b] = '0;
      bwe[b]    = 1'b0;
      bwaddr[b] = '0;
      bwdata[b] = wr_word[0];
      for (int i = 0; i < 2; i++) begin
        if (slot_d[i].valid && (slot_d[i].k[0] == b[0])) begin
          bre[b]    = 1'b1;
          braddr[b] = slot_d[i].k[KW-1:1];
        end
        if (wr_en[i] && (s1_q[i].k[0] == b[0])) begin
          bwe[b]    = 1'b1;
          bwaddr[b] = s1_q[i].k[KW-1:1];
          bwdata[b] = wr_word[i];
        end
      end
    end
  end

  for (genvar gb = 0; gb < 2; gb++) begin : g_bank
    gpr5x5_line_bank #(
      .DEPTH (BANK_DEPTH),
      .AW    (AW)
    ) u_bank (
      .clk_i   (clk_i),
      .re_i    (bre[gb]),
      .raddr_i (braddr[gb]),
      .we_i    (bwe[gb]),
      .waddr_i (bwaddr[gb]),
      .wdata_i (bwdata[gb]),
      .rdata_o (bank_rdata[gb])
    );
  end

  // --------------------------------------------------------------------------
  // Column stage: vertical accumulation, write-back and output scaling.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rd[i]      = bank_rdata[s1_q[i].k[0]];
      wr_word[i] = rd[i];
      wr_en[i]   = 1'b0;
      has_res[i] = 1'b0;
      sum[i]     = '0;
      unique case (s1_q[i].kind)
        EV_FIRST: begin
          // The top row stands in for the two replicated rows above it.
          wr_word[i].cur   = CUR_W'(s1_q[i].s);
          wr_word[i].upper = UPPER_W'({s1_q[i].s, 2'b00}) + UPPER_W'(s1_q[i].s);
          wr_en[i]         = s1_q[i].valid;
        end
        EV_ODD: begin
          wr_word[i].odd = ODD_W'({s1_q[i].s, 2'b00});
          wr_en[i]       = s1_q[i].valid;
        end
        EV_EVEN: begin
          sum[i] = SUM_W'(rd[i].upper) + SUM_W'({rd[i].cur, 2'b00})
                 + SUM_W'({rd[i].cur, 1'b0}) + SUM_W'(rd[i].odd) + SUM_W'(s1_q[i].s);
          wr_word[i].upper = UPPER_W'(rd[i].cur) + UPPER_W'(rd[i].odd);
          wr_word[i].cur   = CUR_W'(s1_q[i].s);
          wr_en[i]         = s1_q[i].valid;
          has_res[i]       = s1_q[i].valid && (s1_q[i].k != '0);
        end
        EV_FLUSH_ODDH: begin
          sum[i] = SUM_W'(rd[i].upper) + SUM_W'({rd[i].cur, 3'b000})
                 + SUM_W'({rd[i].cur, 1'b0}) + SUM_W'(rd[i].cur);
          has_res[i] = s1_q[i].valid;
        end
        EV_FLUSH_EVENH: begin
          sum[i] = SUM_W'(rd[i].upper) + SUM_W'({rd[i].cur, 2'b00})
                 + SUM_W'({rd[i].cur, 1'b0}) + SUM_W'(rd[i].odd)
                 + SUM_W'(rd[i].odd[ODD_W-1:2]);
          has_res[i] = s1_q[i].valid;
        end
        default: ;
      endcase
      scaled[i]        = round_q ? (sum[i] + ROUND_BIAS) : sum[i];
      res[i].pix       = scaled[i][SUM_W-1:SUM_W-PIX_W];
      res[i].row_end   = (s1_q[i].k == dst_w_q);
      res[i].frame_end = (s1_q[i].k == dst_w_q)
                       && (s1_q[i].kind == EV_FLUSH_ODDH || s1_q[i].kind == EV_FLUSH_EVENH);
      res[i].last      = s1_q[i].last;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer and stream ports
  // --------------------------------------------------------------------------
  assign push_n = 2'(has_res[0]) + 2'(has_res[1]);
  assign push0  = has_res[0] ? res[0] : res[1];
  assign pop    = m_axis_tvalid_o && m_axis_tready_i;

  gpr5x5_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (push0),
    .push1_i  (res[1]),
    .pop_i    (pop),
    .head_o   (head),
    .cnt_o    (fifo_cnt)
  );

  // Room is kept for the two results a transfer may still cause.
  assign s_axis_tready_o = (CNT_W1'(fifo_cnt) + CNT_W1'(push_n))
                           <= CNT_W1'(OUT_FIFO_DEPTH - 2);
  assign m_axis_tvalid_o = (fifo_cnt != '0);
  assign m_axis_tdata_o  = head.pix;
  assign m_axis_tuser_o  = {head.frame_end, head.row_end};
  assign m_axis_tlast_o  = head.last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `GPR_ASSERT_ALWAYS(a_slots_split_banks, !(s1_q[0].valid && s1_q[1].valid) || (s1_q[0].k[0] != s1_q[1].k[0]), "two column events hit one bank")
  `GPR_ASSERT_ALWAYS(a_fifo_room, (CNT_W1'(fifo_cnt) + CNT_W1'(push_n)) <= CNT_W1'(OUT_FIFO_DEPTH), "result buffer overflow")
  `GPR_ASSERT_ALWAYS(a_flush_at_origin, !fpend_q || (col_q == '0 && row_q == '0), "flush pending away from frame origin")
  `GPR_ASSERT_ALWAYS(a_col_in_frame, col_q < w_q, "column position beyond source width")
  `GPR_ASSERT_NEXT(a_flush_issues, accept && op_flush && fpend_q, s1_q[0].valid, "flush transfer gave no column event")

endmodule

/* design/gpr5x5_line_bank.sv */
// ----------------------------------------------------------------------------
// Line store bank
// One-read one-write synchronous memory with a registered read port that
// returns the data being written when both ports hit the same entry.
// ----------------------------------------------------------------------------
module gpr5x5_line_bank #(
  parameter int DEPTH = 513,
  parameter int AW    = 10
) (
  input  logic                   clk_i,
  input  logic                   re_i,
  input  logic [AW-1:0]          raddr_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  gpr5x5_pkg::line_word_t wdata_i,
  output gpr5x5_pkg::line_word_t rdata_o
);
  import gpr5x5_pkg::*;

  line_word_t mem_q [DEPTH];
  line_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      // A write landing on the entry being read is forwarded.
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/gpr5x5_out_fifo.sv */
// ----------------------------------------------------------------------------
// Result buffer
// Small queue that takes up to two results per cycle and hands one out.
// ----------------------------------------------------------------------------
module gpr5x5_out_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          push_n_i,
  input  gpr5x5_pkg::result_t                 push0_i,
  input  gpr5x5_pkg::result_t                 push1_i,
  input  logic                                pop_i,
  output gpr5x5_pkg::result_t                 head_o,
  output logic [gpr5x5_pkg::FIFO_CNT_W-1:0]   cnt_o
);
  import gpr5x5_pkg::*;

  result_t                entry_q [OUT_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d, wp_nx;
  logic [FIFO_CNT_W-1:0]  cnt_q, cnt_d;

  assign wp_nx = wp_q + 1'b1;
  assign wp_d  = wp_q + FIFO_PTR_W'(push_n_i);
  assign rp_d  = rp_q + FIFO_PTR_W'(pop_i);
  assign cnt_d = cnt_q + FIFO_CNT_W'(push_n_i) - FIFO_CNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      entry_q[wp_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      entry_q[wp_nx] <= push1_i;
    end
  end

  assign head_o = entry_q[rp_q];
  assign cnt_o  = cnt_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for the 5x5 Gaussian pyramid reduce block
// Streams gray frames of many geometries through the block and checks every
// reduced pixel, with its row, frame and last flags, against a predictor
// that mirrors the row registers and the three column line stores.
// ----------------------------------------------------------------------------
module testbench;
  import gpr5x5_pkg::*;

  localparam int unsigned MAX_DIM       = 2048;
  localparam int unsigned LINE_DEPTH    = (MAX_DIM + 1) / 2 + 1;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned RAND_ITEMS    = 1250;
  localparam int unsigned TAIL_START    = 1050;
  localparam int unsigned CYCLE_LIMIT   = 800000;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pix;
  } src_item_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [CFG_W-1:0]     cfg_data_i      = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [7:0]           s_axis_tdata_i  = '0;
  logic                 s_axis_tuser_i  = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [7:0]           m_axis_tdata_o;
  logic [1:0]           m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  gaussian_pyramid_reduce_5x5 #(
    .MAX_SRC_WIDTH (MAX_DIM),
    .MAX_SRC_HEIGHT(MAX_DIM)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  src_item_t   src_pending  [$];
  result_t     pyr_expected [$];
  int unsigned err_cnt    = 0;
  int unsigned cyc_cnt    = 0;
  int unsigned rand_items = 0;
  int unsigned hold_req   = 0;
  bit          idle_on    = 1'b1;

  // Predictor state: geometry, rounding, row registers and line stores.
  logic [CFG_W-1:0]      geo_w    = CFG_W'(CFG_DIM_RST);
  logic [CFG_W-1:0]      geo_h    = CFG_W'(CFG_DIM_RST);
  logic                  round_on = 1'b1;
  logic [PIX_W-1:0]      hp_prev  = '0;
  logic [ROW_PART_W-1:0] hp_part  = '0;
  logic [ROW_ODD_W-1:0]  hp_odd4  = '0;
  logic [CUR_W-1:0]      vs_cur   [LINE_DEPTH];
  logic [UPPER_W-1:0]    vs_upper [LINE_DEPTH];
  logic [ODD_W-1:0]      vs_odd   [LINE_DEPTH];
  int unsigned           pos_x    = 0;
  int unsigned           pos_y    = 0;
  int unsigned           flush_x  = 0;
  bit                    flush_on = 1'b0;
  result_t               step_res [2];
  int unsigned           step_n;

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] scale_sum(int unsigned sum);
    int unsigned v;
    v = round_on ? sum + ROUND_BIAS : sum;
    return PIX_W'(v >> 8);
  endfunction

  task automatic emit(int unsigned sum, logic re, logic fe);
    step_res[step_n].pix       = scale_sum(sum);
    step_res[step_n].row_end   = re;
    step_res[step_n].frame_end = fe;
    step_res[step_n].last      = 1'b0;
    step_n++;
  endtask

  task automatic clear_frame();
    hp_prev  = '0;
    hp_part  = '0;
    hp_odd4  = '0;
    pos_x    = 0;
    pos_y    = 0;
    flush_x  = 0;
    flush_on = 1'b0;
  endtask

  // A finished horizontal sum for line store entry k of the current row.
  task automatic col_update(int unsigned k, int unsigned s, int unsigned dst_w);
    int unsigned acc;
    if (k >= LINE_DEPTH) return;
    if (pos_y == 0) begin
      vs_cur[k]   = CUR_W'(s);
      vs_upper[k] = UPPER_W'(5 * s);
    end else if (pos_y[0]) begin
      vs_odd[k] = ODD_W'(4 * s);
    end else begin
      acc = vs_upper[k] + 6 * vs_cur[k] + vs_odd[k] + s;
      vs_upper[k] = UPPER_W'(vs_cur[k] + vs_odd[k]);
      vs_cur[k]   = CUR_W'(s);
      if (k != 0) emit(acc, k == dst_w, 1'b0);
    end
  endtask

  task automatic reduce_step(logic op, logic [PIX_W-1:0] p);
    int unsigned w, h, dst_w, x, k, s, sum;
    bit last_col, last_row;
    result_t r;
    w = eff_dim(geo_w);
    h = eff_dim(geo_h);
    dst_w = (w + 1) / 2;
    step_n = 0;
    if (op == OP_FLUSH) begin
      if (flush_on) begin
        k = flush_x + 1;
        if (k >= LINE_DEPTH) k = LINE_DEPTH - 1;
        if (((h - 1) & 1) == 0)
          sum = vs_upper[k] + 11 * vs_cur[k];
        else
          sum = vs_upper[k] + 6 * vs_cur[k] + vs_odd[k] + (vs_odd[k] >> 2);
        emit(sum, k >= dst_w, k >= dst_w);
        if (k >= dst_w) begin
          flush_on = 1'b0;
          flush_x  = 0;
        end else begin
          flush_x++;
        end
      end
    end else if (!flush_on) begin
      x = pos_x;
      last_col = x + 1 >= w;
      last_row = pos_y + 1 >= h;
      k = (x + 1) >> 1;
      if (x == 0) begin
        hp_prev = p;
        hp_part = ROW_PART_W'(5 * p);
        hp_odd4 = ROW_ODD_W'(4 * p);
      end else if (x[0] == 1'b0) begin
        s = hp_part + 6 * hp_prev + hp_odd4 + p;
        col_update(k, s, dst_w);
        hp_part = ROW_PART_W'(hp_prev + hp_odd4);
        hp_prev = p;
      end else begin
        hp_odd4 = ROW_ODD_W'(4 * p);
      end
      if (last_col) begin
        if (x[0] == 1'b0)
          col_update(k + 1, hp_part + 11 * hp_prev, dst_w);
        else
          col_update(k, hp_part + 6 * hp_prev + hp_odd4 + p, dst_w);
        pos_x = 0;
        if (last_row) begin
          pos_y    = 0;
          flush_on = 1'b1;
          flush_x  = 0;
        end else begin
          pos_y++;
        end
      end else begin
        pos_x++;
      end
    end
    for (int i = 0; i < step_n; i++) begin
      r = step_res[i];
      r.last = (i == step_n - 1);
      pyr_expected.push_back(r);
    end
  endtask

  // Source side: holds each item until its transfer, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin : src_drive
    src_item_t   nxt;
    int unsigned tx_gap;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) reduce_step(s_axis_tuser_i, s_axis_tdata_i);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (src_pending.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
          tx_gap = $urandom_range(0, 6);
          s_axis_tvalid_i <= 1'b0;
        end else if (src_pending.size() != 0) begin
          nxt = src_pending.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= nxt.op;
          s_axis_tdata_i  <= nxt.pix;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result side: checks each transfer and applies back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin : res_check
    result_t     got, want;
    int unsigned rx_gap, hold_left, hold_seen;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      rx_gap    = 0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.pix       = m_axis_tdata_o;
        got.row_end   = m_axis_tuser_o[0];
        got.frame_end = m_axis_tuser_o[1];
        got.last      = m_axis_tlast_o;
        if (pyr_expected.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: pixel %0d row_end %b frame_end %b last %b",
                     got.pix, got.row_end, got.frame_end, got.last);
        end else begin
          want = pyr_expected.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected pixel %0d row_end %b frame_end %b last %b, %s",
                       want.pix, want.row_end, want.frame_end, want.last, "got",
                       " pixel %0d row_end %b frame_end %b last %b",
                       got.pix, got.row_end, got.frame_end, got.last);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(0, 6);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_item(logic op, logic [PIX_W-1:0] pix);
    src_item_t it;
    it.op  = op;
    it.pix = pix;
    src_pending.push_back(it);
  endtask

  task automatic push_pixels(int unsigned n);
    for (int i = 0; i < n; i++) push_item(OP_PIXEL, rand_pixel());
    rand_items += n;
  endtask

  // Flush ticks for the last output row; a noisy run slips in pixels that
  // the block must drop and ends with one tick that has nothing to flush.
  task automatic push_flushes(int unsigned dst_w, bit noisy);
    for (int i = 0; i < dst_w; i++) begin
      if (noisy && $urandom_range(0, 3) == 0) push_item(OP_PIXEL, rand_pixel());
      push_item(OP_FLUSH, rand_pixel());
    end
    if (noisy) push_item(OP_FLUSH, rand_pixel());
    rand_items += dst_w;
  endtask

  // Returns once both streams and the block have been quiet for a while.
  task automatic wait_idle();
    int unsigned quiet;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk_i);
      if (src_pending.size() != 0 || s_axis_tvalid_i || m_axis_tvalid_o
          || pyr_expected.size() != 0)
        quiet = 0;
      else
        quiet++;
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SRC_WIDTH: begin
        geo_w = data;
        clear_frame();
      end
      REG_SRC_HEIGHT: begin
        geo_h = data;
        clear_frame();
      end
      REG_ROUNDING: round_on = data[0];
      default: ;
    endcase
  endtask

  initial begin
    logic [PIX_W-1:0] pattern [9];
    int unsigned w, h, frames, style, split;
    pattern = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A flush straight after reset has nothing to flush.
    push_item(OP_FLUSH, 8'hA5);
    wait_idle();
    cfg_write(REG_SPARE, '1);
    cfg_write(REG_SRC_WIDTH, 12'd3);
    cfg_write(REG_SRC_HEIGHT, 12'd3);
    foreach (pattern[i]) push_item(OP_PIXEL, pattern[i]);
    push_item(OP_FLUSH, 8'h00);
    push_item(OP_PIXEL, 8'hFF);
    push_item(OP_FLUSH, 8'hFF);
    push_item(OP_FLUSH, 8'h00);
    wait_idle();

    // Width 0 behaves as a single column, so even rows give one result.
    cfg_write(REG_ROUNDING, 12'd0);
    cfg_write(REG_SRC_WIDTH, 12'd0);
    cfg_write(REG_SRC_HEIGHT, 12'd2);
    push_item(OP_PIXEL, 8'd255);
    push_item(OP_PIXEL, 8'd0);
    push_item(OP_FLUSH, 8'd0);
    wait_idle();
    cfg_write(REG_SRC_WIDTH, 12'd2);
    cfg_write(REG_SRC_HEIGHT, 12'd1);
    push_item(OP_PIXEL, 8'd255);
    push_item(OP_PIXEL, 8'd255);
    push_item(OP_FLUSH, 8'd0);
    wait_idle();

    // Out-of-range geometry clamps; the partial frames are abandoned.
    cfg_write(REG_ROUNDING, 12'd1);
    cfg_write(REG_SRC_WIDTH, 12'd4095);
    cfg_write(REG_SRC_HEIGHT, 12'd0);
    push_pixels(40);
    wait_idle();
    cfg_write(REG_SRC_WIDTH, 12'd5);
    push_pixels(5);
    push_flushes(3, 1'b1);
    wait_idle();
    cfg_write(REG_SRC_WIDTH, 12'd1);
    cfg_write(REG_SRC_HEIGHT, 12'd4095);
    push_pixels(7);
    wait_idle();

    // The receiver stalls while a full frame is offered back to back.
    rand_items = 0;
    cfg_write(REG_SRC_WIDTH, 12'd16);
    cfg_write(REG_SRC_HEIGHT, 12'd6);
    idle_on = 1'b0;
    hold_req++;
    push_pixels(96);
    push_flushes(8, 1'b0);

    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 64) : $urandom_range(1, 14);
      h = $urandom_range(1, 8);
      cfg_write(REG_SRC_WIDTH, CFG_W'(w));
      cfg_write(REG_SRC_HEIGHT, CFG_W'(h));
      if ($urandom_range(0, 1) == 1) cfg_write(REG_ROUNDING, CFG_W'($urandom_range(0, 1)));
      idle_on = (rand_items < TAIL_START) && ($urandom_range(0, 3) != 0);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        style = $urandom_range(0, 9);
        if (style == 0) begin
          // Cut the frame short; the next geometry write abandons it.
          push_pixels($urandom_range(1, w * h));
          break;
        end
        if (style == 1) begin
          // Drain mid-frame and change rounding before carrying on.
          split = $urandom_range(1, w * h);
          push_pixels(split);
          wait_idle();
          cfg_write(REG_ROUNDING, CFG_W'($urandom_range(0, 1)));
          push_pixels(w * h - split);
        end else begin
          push_pixels(w * h);
        end
        push_flushes((w + 1) / 2, style == 2 || style == 3);
      end
    end

    idle_on = 1'b0;
    wait_idle();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
